// ===== rtl/fbvs_pkg.sv =====
// Shared widths and constants for the fluid boundary velocity slip block.
package fbvs_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NORMAL_FRAC   = 14;
  localparam int VEL_W         = 32;
  localparam int NRM_W         = 16;
  localparam int DAMP_W        = 31;
  localparam logic [DAMP_W-1:0] DAMP_RESET = 31'd13107;
endpackage

// ===== rtl/fbvs_in_if.sv =====
// Input channel: one voxel per transaction.
interface fbvs_in_if;
  import fbvs_pkg::*;
  logic valid;
  logic ready;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] vel_z;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic signed [VEL_W-1:0] boundary_distance;
  logic end_of_field;
  modport source (output valid, vel_x, vel_y, vel_z, normal_x, normal_y, normal_z,
                  boundary_distance, end_of_field, input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, normal_x, normal_y, normal_z,
                boundary_distance, end_of_field, output ready);
endinterface

// ===== rtl/fbvs_out_if.sv =====
// Output channel: one adjusted velocity per transaction.
interface fbvs_out_if;
  import fbvs_pkg::*;
  logic valid;
  logic ready;
  logic signed [VEL_W-1:0] new_vel_x;
  logic signed [VEL_W-1:0] new_vel_y;
  logic signed [VEL_W-1:0] new_vel_z;
  logic last_cell;
  modport source (output valid, new_vel_x, new_vel_y, new_vel_z, last_cell, input ready);
  modport sink (input valid, new_vel_x, new_vel_y, new_vel_z, last_cell, output ready);
endinterface

// ===== rtl/fbvs_divu.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
module fbvs_divu #(
  parameter int DW = 32,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] hi,
  input  logic [QW-1:0] lo,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] q
);
  logic [DW-1:0] rem_s [QW];
  logic [QW-1:0] q_s   [QW];
  logic [QW-1:0] lo_s  [QW-1];
  logic [DW-1:0] den_s [QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] r_in;
    logic [QW-1:0] l_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   trial;
    logic          ge;
    if (k == 0) begin : g_first
      assign r_in = hi;
      assign l_in = lo;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_s[k-1];
      assign l_in = lo_s[k-1];
      assign d_in = den_s[k-1];
      assign q_in = q_s[k-1];
    end
    always_comb begin
      trial = {r_in, l_in[QW-1]};
      ge    = trial >= {1'b0, d_in};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= ge ? DW'(trial - {1'b0, d_in}) : DW'(trial);
        q_s[k]   <= {q_in[QW-2:0], ge};
      end
    end
    if (k < QW-1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          lo_s[k]  <= l_in << 1;
          den_s[k] <= d_in;
        end
      end
    end
  end

  assign q = q_s[QW-1];
endmodule

// ===== rtl/fbvs_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module fbvs_isqrt #(
  parameter int RW = 32
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] x,
  output logic [RW-1:0]   root
);
  localparam int XW = 2*RW;

  logic [RW-1:0] root_s [RW];
  logic [RW:0]   rem_s  [RW-1];
  logic [XW-1:0] x_s    [RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW:0]   r_in;
    logic [XW-1:0] x_in;
    logic [RW-1:0] o_in;
    logic [RW+2:0] cand;
    logic [RW+2:0] test;
    logic          ge;
    if (k == 0) begin : g_first
      assign r_in = '0;
      assign x_in = x;
      assign o_in = '0;
    end else begin : g_next
      assign r_in = rem_s[k-1];
      assign x_in = x_s[k-1];
      assign o_in = root_s[k-1];
    end
    always_comb begin
      cand = {r_in, x_in[XW-1:XW-2]};
      test = {1'b0, o_in, 2'b01};
      ge   = cand >= test;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        root_s[k] <= {o_in[RW-2:0], ge};
      end
    end
    if (k < RW-1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[k] <= ge ? (RW+1)'(cand - test) : (RW+1)'(cand);
          x_s[k]   <= x_in << 2;
        end
      end
    end
  end

  assign root = root_s[RW-1];
endmodule

// ===== rtl/fluid_boundary_velocity_slip_unit.sv =====
// Fluid boundary velocity slip: top level, 76-stage pipeline.
//
// cell_in carries one voxel per transaction: velocity, boundary normal,
// signed boundary distance and an end-of-field mark. cell_out returns the
// adjusted velocity for the same voxel, in order, with last_cell copied.
// cfg_wen/cfg_wdata write the damping distance; write it only while no
// voxel is in flight. A damping of zero acts as one.
// One voxel is taken every cycle unless the output stalls: the depth is set
// by a 32-stage square root and a 32-stage divider in series, one result
// bit per stage, plus twelve arithmetic stages.
// The whole pipeline advances together; when cell_out is valid and not
// ready, every stage holds and cell_in.ready drops, and no transaction is
// lost or repeated. Bubbles travel with their valid bits.
// Synchronous reset clears all valid bits and loads the damping reset
// value; no clearing pass is needed.
module fluid_boundary_velocity_slip_unit #(
  parameter int FRAC_BITS = fbvs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  fbvs_in_if.sink                     cell_in,
  fbvs_out_if.source                  cell_out,
  input  logic                        cfg_wen,
  input  logic [fbvs_pkg::DAMP_W-1:0] cfg_wdata
);
  import fbvs_pkg::*;

  localparam int LAT   = 76;
  localparam int CL    = 75;
  localparam int TD    = 73 - FRAC_BITS;
  localparam int ONE_W = FRAC_BITS + 1;
  localparam int AW    = FRAC_BITS + 36;
  localparam int RSH   = 2 * NORMAL_FRAC;
  localparam logic [ONE_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [36:0] WS_LIM = 37'h0_8000_0000;
  localparam logic [65:0] C_HALF = 66'(1) << (RSH - 1);
  localparam logic [AW-1:0] R_HALF = AW'(1) << (FRAC_BITS - 1);
  localparam logic signed [AW-1:0] SMAX = AW'($signed(32'h7fff_ffff));
  localparam logic signed [AW-1:0] SMIN = AW'($signed(32'h8000_0000));

  typedef struct packed {
    logic [2:0][VEL_W-1:0] v;
    logic                  eof;
  } carry_t;

  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
  } sgn_t;

  logic [DAMP_W-1:0] damping;
  logic [DAMP_W-1:0] dmp;
  logic              adv;
  logic [LAT:1]      vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      damping <= DAMP_RESET;
    end else if (cfg_wen) begin
      damping <= cfg_wdata;
    end
  end
  assign dmp = (damping == '0) ? DAMP_W'(1) : damping;

  assign adv           = !vld[LAT] || cell_out.ready;
  assign cell_in.ready = adv;
  assign cell_out.valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-1:1], cell_in.valid};
    end
  end

  logic signed [VEL_W-1:0] vin [3];
  logic signed [NRM_W-1:0] nin [3];
  logic [VEL_W-1:0]        vmag [3];
  logic [VEL_W-1:0]        dmag;
  carry_t                  cin;

  assign vin[0] = cell_in.vel_x;
  assign vin[1] = cell_in.vel_y;
  assign vin[2] = cell_in.vel_z;
  assign nin[0] = cell_in.normal_x;
  assign nin[1] = cell_in.normal_y;
  assign nin[2] = cell_in.normal_z;
  assign cin.v   = {cell_in.vel_z, cell_in.vel_y, cell_in.vel_x};
  assign cin.eof = cell_in.end_of_field;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vmag[i] = vin[i][VEL_W-1] ? VEL_W'(-vin[i]) : VEL_W'(vin[i]);
    end
    dmag = cell_in.boundary_distance[VEL_W-1] ? VEL_W'(-cell_in.boundary_distance)
                                              : VEL_W'(cell_in.boundary_distance);
  end

  // carry line: cline[k] is stage k+1
  carry_t cline [CL];
  always_ff @(posedge clk) begin
    if (adv) begin
      cline[0] <= cin;
      for (int k = 1; k < CL; k++) cline[k] <= cline[k-1];
    end
  end

  // stage 1: products
  logic signed [47:0]      p1 [3];
  logic [63:0]             sq1 [3];
  logic signed [NRM_W-1:0] n1 [3];
  logic [VEL_W-1:0]        dm1;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p1[i]  <= 48'(vin[i]) * 48'(nin[i]);
        sq1[i] <= 64'(vmag[i]) * 64'(vmag[i]);
        n1[i]  <= nin[i];
      end
      dm1 <= dmag;
    end
  end

  // influence factor
  logic              t_gt, t_full;
  logic [VEL_W-1:0]  t_diff;
  logic [DAMP_W-1:0] t_hi;
  logic [FRAC_BITS-1:0] tq;
  logic              tfl [FRAC_BITS];
  logic [ONE_W-1:0]  t_c;
  logic [ONE_W-1:0]  tline [TD];

  always_comb begin
    t_gt   = dm1 > {1'b0, dmp};
    t_diff = dm1 - {1'b0, dmp};
    t_full = t_gt && (t_diff >= {1'b0, dmp});
    t_hi   = (t_gt && !t_full) ? t_diff[DAMP_W-1:0] : '0;
  end

  fbvs_divu #(.DW(DAMP_W), .QW(FRAC_BITS)) u_tdiv (
    .clk (clk),
    .en  (adv),
    .hi  (t_hi),
    .lo  ({FRAC_BITS{1'b0}}),
    .den (dmp),
    .q   (tq)
  );

  assign t_c = tfl[FRAC_BITS-1] ? ONE : {1'b0, tq};

  always_ff @(posedge clk) begin
    if (adv) begin
      tfl[0] <= t_full;
      for (int k = 1; k < FRAC_BITS; k++) tfl[k] <= tfl[k-1];
      tline[0] <= t_c;
      for (int k = 1; k < TD; k++) tline[k] <= tline[k-1];
    end
  end

  // stage 2: sums
  logic signed [49:0]      dot2;
  logic [63:0]             sqs2;
  logic signed [NRM_W-1:0] n2 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      dot2 <= 50'(p1[0]) + 50'(p1[1]) + 50'(p1[2]);
      sqs2 <= sq1[0] + sq1[1] + sq1[2];
      for (int i = 0; i < 3; i++) n2[i] <= n1[i];
    end
  end

  logic [31:0] speed;
  fbvs_isqrt #(.RW(32)) u_speed (
    .clk  (clk),
    .en   (adv),
    .x    (sqs2),
    .root (speed)
  );

  // stage 3: normal part
  logic signed [65:0] nd3 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) nd3[i] <= 66'(n2[i]) * 66'(dot2);
    end
  end

  // stage 4: remainder
  logic [65:0]        ndm [3];
  logic [37:0]        cm [3];
  logic signed [37:0] cc [3];
  logic signed [37:0] w4 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ndm[i] = nd3[i][65] ? 66'(-nd3[i]) : 66'(nd3[i]);
      cm[i]  = 38'((ndm[i] + C_HALF) >> RSH);
      cc[i]  = nd3[i][65] ? -$signed(cm[i]) : $signed(cm[i]);
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        w4[i] <= 38'($signed(cline[2].v[i])) - cc[i];
      end
    end
  end

  // stage 5: magnitudes and maximum
  logic [36:0] wmc [3];
  logic [36:0] maxc;
  logic [36:0] wm5 [3];
  logic [36:0] maxm5;
  logic [2:0]  neg5;
  always_comb begin
    maxc = '0;
    for (int i = 0; i < 3; i++) begin
      wmc[i] = w4[i][37] ? 37'(-w4[i]) : 37'(w4[i]);
      if (wmc[i] > maxc) maxc = wmc[i];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        wm5[i]  <= wmc[i];
        neg5[i] <= w4[i][37];
      end
      maxm5 <= maxc;
    end
  end

  // stage 6: scale into 31 bits
  logic [2:0]  sh;
  logic [30:0] ws6 [3];
  sgn_t        sg6;
  always_comb begin
    sh = '0;
    for (int k = 5; k >= 0; k--) begin
      if ((maxm5 >> k) < WS_LIM) sh = 3'(k);
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) ws6[i] <= 31'(wm5[i] >> sh);
      sg6.zero <= maxm5 == '0;
      sg6.neg  <= neg5;
    end
  end

  // stages 7 and 8: squared length of the scaled remainder
  logic [61:0] wsq7 [3];
  logic [63:0] ssum8;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) wsq7[i] <= 62'(ws6[i]) * 62'(ws6[i]);
      ssum8 <= 64'(wsq7[0]) + 64'(wsq7[1]) + 64'(wsq7[2]);
    end
  end

  logic [31:0] wn;
  fbvs_isqrt #(.RW(32)) u_wlen (
    .clk  (clk),
    .en   (adv),
    .x    (ssum8),
    .root (wn)
  );

  // align scaled remainder, speed and sign flags
  logic [2:0][30:0] wsl [34];
  logic [31:0]      spl [6];
  sgn_t             zl  [68];
  always_ff @(posedge clk) begin
    if (adv) begin
      wsl[0] <= {ws6[2], ws6[1], ws6[0]};
      for (int k = 1; k < 34; k++) wsl[k] <= wsl[k-1];
      spl[0] <= speed;
      for (int k = 1; k < 6; k++) spl[k] <= spl[k-1];
      zl[0] <= sg6;
      for (int k = 1; k < 68; k++) zl[k] <= zl[k-1];
    end
  end

  // stages 41 and 42: numerators of the rescale
  logic [62:0] prod41 [3];
  logic [31:0] wn41, wn42;
  logic [63:0] n42 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prod41[i] <= 63'(wsl[33][i]) * 63'(spl[5]);
        n42[i]    <= 64'(prod41[i]) + 64'(wn41 >> 1);
      end
      wn41 <= wn;
      wn42 <= wn41;
    end
  end

  logic [31:0] mq [3];
  for (genvar i = 0; i < 3; i++) begin : g_rdiv
    fbvs_divu #(.DW(32), .QW(32)) u_rdiv (
      .clk (clk),
      .en  (adv),
      .hi  (n42[i][63:32]),
      .lo  (n42[i][31:0]),
      .den (wn42),
      .q   (mq[i])
    );
  end

  // stage 75: blend products
  logic signed [33:0]   res [3];
  logic [ONE_W-1:0]     omt;
  logic signed [AW-1:0] a75 [3];
  logic signed [AW-1:0] b75 [3];
  always_comb begin
    omt = ONE - tline[TD-1];
    for (int i = 0; i < 3; i++) begin
      if (zl[67].zero) begin
        res[i] = '0;
      end else if (zl[67].neg[i]) begin
        res[i] = -$signed(34'(mq[i]));
      end else begin
        res[i] = $signed(34'(mq[i]));
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a75[i] <= AW'(res[i]) * AW'($signed({1'b0, omt}));
        b75[i] <= AW'($signed(cline[73].v[i])) * AW'($signed({1'b0, tline[TD-1]}));
      end
    end
  end

  // stage 76: round, saturate, output register
  logic signed [AW-1:0] acc [3];
  logic [AW-1:0]        amag [3];
  logic [AW-1:0]        rnd [3];
  logic signed [AW-1:0] rs [3];
  logic [VEL_W-1:0]     sat [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i]  = a75[i] + b75[i];
      amag[i] = acc[i][AW-1] ? AW'(-acc[i]) : AW'(acc[i]);
      rnd[i]  = (amag[i] + R_HALF) >> FRAC_BITS;
      rs[i]   = acc[i][AW-1] ? -$signed(rnd[i]) : $signed(rnd[i]);
      if (rs[i] > SMAX) begin
        sat[i] = SMAX[VEL_W-1:0];
      end else if (rs[i] < SMIN) begin
        sat[i] = SMIN[VEL_W-1:0];
      end else begin
        sat[i] = rs[i][VEL_W-1:0];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      cell_out.new_vel_x <= sat[0];
      cell_out.new_vel_y <= sat[1];
      cell_out.new_vel_z <= sat[2];
      cell_out.last_cell <= cline[74].eof;
    end
  end

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) rst |=> !cell_out.valid)
    else $error("output valid after reset");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst) !adv |=> $stable(vld))
    else $error("pipeline moved while stalled");
  a_enter: assert property (@(posedge clk) disable iff (rst)
    cell_in.valid && cell_in.ready |=> vld[1])
    else $error("accepted transaction not in first stage");
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    vld[LAT] && !cell_out.ready |-> !cell_in.ready)
    else $error("input taken while output stalled");
`endif
endmodule
